/* sv/gemm_pkg.sv */
// ----------------------------------------------------------------------------
// gemm_pkg
// shared types and constants for the matrix multiply-accumulate block
// ----------------------------------------------------------------------------
`default_nettype none
package gemm_pkg;
  localparam int MaxDim = 16;
  localparam int DimLim = (MaxDim < 16) ? MaxDim : 16;
  localparam int IdxW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = MaxDim * MaxDim;
  localparam int CntW = $clog2(DimLim + 1);

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_LOAD_C = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_ROWS_M = 3'd0,
    CFG_COLS_N = 3'd1,
    CFG_DEPTH_K = 3'd2,
    CFG_TRANS_A = 3'd3,
    CFG_TRANS_B = 3'd4,
    CFG_ALPHA = 3'd5,
    CFG_BETA = 3'd6,
    CFG_NONE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] row_index;
    logic [3:0] col_index;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_row;
    logic [3:0] out_col;
    logic signed [31:0] out_value;
    logic last_of_row;
  } out_item_t;

  // control handed from sequencer into the cell row
  typedef struct packed {
    logic load;
    logic shift;
    logic valid;
    logic last;
    logic [3:0] col;
  } cell_ctl_t;

  function automatic logic [CntW-1:0] clamp_dim(input logic [4:0] d);
    if (d == 5'd0) return CntW'(1);
    if (int'(d) > DimLim) return CntW'(DimLim);
    return CntW'(d);
  endfunction
endpackage
`default_nettype wire

/* sv/general_matrix_multiply_accumulate.sv */
// ----------------------------------------------------------------------------
// general_matrix_multiply_accumulate
// C = beta*C + alpha*op(A)*op(B), one output row per compute transaction
// ----------------------------------------------------------------------------
// A compute transaction runs one accumulator cell per column; all cells take
// one k term per cycle, and then the n results shift out of the cell chain,
// one per cycle, with strobe high; the receiver cannot stall. busy is high
// throughout.
`default_nettype none
module general_matrix_multiply_accumulate (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire gemm_pkg::in_item_t req,
  output logic strobe,
  output gemm_pkg::out_item_t result,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gemm_pkg::*;

  logic [4:0] rows_m, cols_n, depth_k;
  logic transpose_a, transpose_b;
  logic signed [15:0] alpha_scale, beta_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m <= 5'd16;
      cols_n <= 5'd16;
      depth_k <= 5'd16;
      transpose_a <= 1'b0;
      transpose_b <= 1'b0;
      alpha_scale <= 16'sd256;
      beta_scale <= 16'sd256;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_M: rows_m <= cfg_data[4:0];
        CFG_COLS_N: cols_n <= cfg_data[4:0];
        CFG_DEPTH_K: depth_k <= cfg_data[4:0];
        CFG_TRANS_A: transpose_a <= cfg_data[0];
        CFG_TRANS_B: transpose_b <= cfg_data[0];
        CFG_ALPHA: alpha_scale <= cfg_data[15:0];
        CFG_BETA: beta_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gemm_core u_core (
    .clk(clk), .rst(rst), .go(start && !busy), .item(req),
    .m_eff(clamp_dim(rows_m)), .n_eff(clamp_dim(cols_n)),
    .k_eff(clamp_dim(depth_k)), .ta(transpose_a), .tb(transpose_b),
    .alpha(alpha_scale), .beta(beta_scale),
    .busy(busy), .res_strobe(strobe), .res(result)
  );
endmodule
`default_nettype wire

/* sv/gemm_cell.sv */
// ----------------------------------------------------------------------------
// gemm_cell
// one accumulator cell: holds one output column, takes one product per cycle,
// then passes its finished value down the chain
// ----------------------------------------------------------------------------
`default_nettype none
module gemm_cell (
  input  wire logic clk,
  input  wire gemm_pkg::cell_ctl_t ctl,
  input  wire logic signed [47:0] init_value,
  input  wire logic add_en,
  input  wire logic signed [47:0] term,
  input  wire logic signed [47:0] chain_in,
  input  wire logic [3:0] chain_col_in,
  output logic signed [47:0] acc,
  output logic [3:0] col
);
  import gemm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= init_value;
      col <= ctl.col;
    end else if (ctl.shift) begin
      acc <= chain_in;
      col <= chain_col_in;
    end else if (add_en) begin
      acc <= acc + term;
    end
  end
endmodule
`default_nettype wire

/* sv/gemm_core.sv */
// ----------------------------------------------------------------------------
// gemm_core
// stores, sequencer and row of accumulator cells
// ----------------------------------------------------------------------------
`default_nettype none
module gemm_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire gemm_pkg::in_item_t item,
  input  wire logic [gemm_pkg::CntW-1:0] m_eff,
  input  wire logic [gemm_pkg::CntW-1:0] n_eff,
  input  wire logic [gemm_pkg::CntW-1:0] k_eff,
  input  wire logic ta,
  input  wire logic tb,
  input  wire logic signed [15:0] alpha,
  input  wire logic signed [15:0] beta,
  output logic busy,
  output logic res_strobe,
  output gemm_pkg::out_item_t res
);
  import gemm_pkg::*;

  logic [15:0] a_mem [Depth];

  state_t state, state_next;
  logic [IdxW-1:0] row;
  logic [CntW-1:0] ph, ph_next;
  logic [CntW-1:0] kc;
  logic [CntW-1:0] oc;
  logic signed [47:0] accs [DimLim];
  logic [3:0] cols [DimLim];
  logic signed [47:0] terms [DimLim];
  logic signed [47:0] inits [DimLim];
  cell_ctl_t ctls [DimLim];

  // phases: 0 read c, 1 init cells, 2..: k steps (read a/b column per step)
  logic [31:0] c_rd [DimLim];
  logic [15:0] a_rd;
  logic [15:0] b_rd [DimLim];
  logic [15:0] b_d [DimLim];
  logic signed [31:0] ap;
  logic add_en;
  logic load_cells, shift_cells;
  logic [IdxW-1:0] kidx;
  logic load_ok;

  assign kidx = kc[IdxW-1:0];
  assign load_ok = go && state == ST_IDLE && item.req_type != REQ_COMPUTE &&
                   int'(item.row_index) < DimLim && int'(item.col_index) < DimLim;

  always_ff @(posedge clk) begin
    if (load_ok && item.req_type == REQ_LOAD_A)
      a_mem[{item.row_index[IdxW-1:0], item.col_index[IdxW-1:0]}] <= item.load_value[15:0];
  end

  // each lane keeps its own column of c, its column of b and its row of b
  for (genvar j = 0; j < DimLim; j++) begin : g_lane
    logic [15:0] b_col [MaxDim];
    logic [15:0] b_row [MaxDim];
    logic [31:0] c_bank [MaxDim];
    always_ff @(posedge clk) begin
      if (load_ok && item.req_type == REQ_LOAD_B && int'(item.col_index) == j)
        b_col[item.row_index[IdxW-1:0]] <= item.load_value[15:0];
      if (load_ok && item.req_type == REQ_LOAD_B && int'(item.row_index) == j)
        b_row[item.col_index[IdxW-1:0]] <= item.load_value[15:0];
      if (load_ok && item.req_type == REQ_LOAD_C && int'(item.col_index) == j)
        c_bank[item.row_index[IdxW-1:0]] <= item.load_value;
      else if (state == ST_DRAIN && cols[0][IdxW-1:0] == IdxW'(j))
        c_bank[row] <= res.out_value;
      c_rd[j] <= c_bank[row];
      b_rd[j] <= tb ? b_row[kidx] : b_col[kidx];
      b_d[j] <= b_rd[j];
    end
    logic signed [63:0] bc;
    logic signed [47:0] pr;
    assign bc = 64'(beta) * 64'($signed(c_rd[j]));
    assign inits[j] = 48'(bc >>> 8);
    always_ff @(posedge clk) pr <= 48'(ap) * 48'($signed(b_d[j]));
    assign terms[j] = pr >>> 8;
    assign ctls[j] = '{load: load_cells, shift: shift_cells, valid: 1'b1,
                       last: 1'b0, col: 4'(j)};
    gemm_cell u_cell (
      .clk(clk), .ctl(ctls[j]), .init_value(inits[j]), .add_en(add_en),
      .term(terms[j]),
      .chain_in((j + 1 < DimLim) ? accs[(j + 1) % DimLim] : 48'sd0),
      .chain_col_in((j + 1 < DimLim) ? cols[(j + 1) % DimLim] : 4'd0),
      .acc(accs[j]), .col(cols[j])
    );
  end

  always_ff @(posedge clk) begin
    a_rd <= ta ? a_mem[{kidx, row}] : a_mem[{row, kidx}];
    ap <= 32'(alpha) * 32'($signed(a_rd));
  end

  // pipeline: kc issues address, a_rd/b_rd next, ap/b_d next, pr next, add next
  logic [2:0] addv;
  always_ff @(posedge clk) begin
    if (rst) addv <= '0;
    else addv <= {addv[1:0], (state == ST_RUN && ph >= CntW'(2) && kc < k_eff)};
  end
  assign add_en = addv[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph <= '0;
      kc <= '0;
      oc <= '0;
    end else begin
      state <= state_next;
      ph <= ph_next;
      if (state == ST_IDLE) begin
        kc <= '0;
        oc <= '0;
        if (go && item.req_type == REQ_COMPUTE) row <= item.row_index[IdxW-1:0];
      end else if (state == ST_RUN && ph >= CntW'(2) && kc < k_eff) begin
        kc <= kc + 1'b1;
      end else if (state == ST_DRAIN) begin
        oc <= oc + 1'b1;
      end
    end
  end

  logic [CntW+2:0] run_end;
  assign run_end = (CntW + 3)'(k_eff) + (CntW + 3)'(5);

  always_comb begin
    state_next = state;
    ph_next = ph;
    load_cells = 1'b0;
    shift_cells = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ph_next = '0;
        if (go && item.req_type == REQ_COMPUTE && CntW'(item.row_index) < m_eff)
          state_next = ST_RUN;
      end
      ST_RUN: begin
        if (ph != '1) ph_next = ph + 1'b1;
        if (ph == CntW'(1)) load_cells = 1'b1;
        if ((CntW + 3)'(ph) == run_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        shift_cells = 1'b1;
        if (oc + 1'b1 == n_eff) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ph counter must cover k+5; widen via separate counter if needed
  logic signed [31:0] sat;
  always_comb begin
    if (accs[0] > 48'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
    else if (accs[0] < -48'sh80000000) sat = 32'sh80000000;
    else sat = accs[0][31:0];
  end

  assign busy = (state != ST_IDLE);
  assign res_strobe = (state == ST_DRAIN);
  assign res = '{out_row: 4'(row), out_col: cols[0], out_value: sat,
                 last_of_row: (oc + 1'b1 == n_eff)};
endmodule
`default_nettype wire

/* sv/gemm_checker.sv */
// ----------------------------------------------------------------------------
// gemm_checker
// port-level checks on the matrix multiply-accumulate block
// ----------------------------------------------------------------------------
`default_nettype none
module gemm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic strobe,
  input wire gemm_pkg::out_item_t result
);
  import gemm_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside busy");
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) |-> result.out_col == $past(result.out_col) + 4'd1)
    else $error("column order");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_of_row |=> !strobe) else $error("result after last");
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) |-> $stable(result.out_row)) else $error("row");
endmodule

bind general_matrix_multiply_accumulate gemm_checker u_gemm_checker (
  .clk(clk), .rst(rst), .busy(busy), .strobe(strobe), .result(result)
);
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the matrix multiply-accumulate block: directed
// register writes and a table of loads and computes, then random phases with
// shadow stores and a row predictor, idle gaps on the request side
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import gemm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t req = '0;
  logic strobe;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_NONE;
  logic [31:0] cfg_data = '0;

  general_matrix_multiply_accumulate uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .strobe(strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow state
  logic [15:0] a_mem [256];
  logic [15:0] b_mem [256];
  logic [31:0] c_mem [256];
  bit a_set [256];
  bit b_set [256];
  bit c_set [256];
  logic [4:0] m_reg, n_reg, k_reg;
  logic ta_reg, tb_reg;
  logic signed [15:0] alpha_reg, beta_reg;

  out_item_t row_expected [$];
  int errors = 0;
  int idle_cycles = 0;
  int results_seen = 0;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] r;
    logic [3:0] c;
    logic [31:0] v;
    bit typed;
    logic [31:0] want;
  } dir_row_t;

  function automatic int dim(input logic [4:0] d);
    if (d == 0) return 1;
    if (d > 16) return 16;
    return int'(d);
  endfunction

  function automatic longint floor8(input longint x);
    return x >>> 8;
  endfunction

  function automatic bit row_ready(input int r);
    int n, k;
    n = dim(n_reg);
    k = dim(k_reg);
    if (r >= dim(m_reg)) return 1'b1;
    for (int j = 0; j < n; j++) begin
      if (!c_set[r*16+j]) return 1'b0;
      for (int q = 0; q < k; q++) begin
        if (!a_set[ta_reg ? q*16+r : r*16+q]) return 1'b0;
        if (!b_set[tb_reg ? j*16+q : q*16+j]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_item(input in_item_t it);
    int n, k, addr;
    longint acc, ap;
    out_item_t o;
    n = dim(n_reg);
    k = dim(k_reg);
    addr = it.row_index * 16 + it.col_index;
    case (req_t'(it.req_type))
      REQ_LOAD_A: begin a_mem[addr] = it.load_value[15:0]; a_set[addr] = 1; end
      REQ_LOAD_B: begin b_mem[addr] = it.load_value[15:0]; b_set[addr] = 1; end
      REQ_LOAD_C: begin c_mem[addr] = it.load_value; c_set[addr] = 1; end
      default: begin
        if (it.row_index < dim(m_reg)) begin
          for (int j = 0; j < n; j++) begin
            acc = floor8(longint'(beta_reg) * longint'($signed(c_mem[it.row_index*16+j])));
            for (int q = 0; q < k; q++) begin
              ap = longint'(alpha_reg) *
                   longint'($signed(a_mem[ta_reg ? q*16+it.row_index : it.row_index*16+q]));
              acc += floor8(ap * longint'($signed(b_mem[tb_reg ? j*16+q : q*16+j])));
            end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            c_mem[it.row_index*16+j] = acc[31:0];
            o.out_row = it.row_index;
            o.out_col = j[3:0];
            o.out_value = acc[31:0];
            o.last_of_row = (j == n - 1);
            row_expected.push_back(o);
          end
        end
      end
    endcase
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && strobe) begin
      out_item_t e;
      results_seen++;
      if (row_expected.size() == 0) begin
        $error("unexpected result row %0d col %0d", result.out_row, result.out_col);
        errors++;
      end else begin
        e = row_expected.pop_front();
        if (result.out_row !== e.out_row) begin
          $error("out_row expected %0d actual %0d", e.out_row, result.out_row); errors++;
        end
        if (result.out_col !== e.out_col) begin
          $error("out_col expected %0d actual %0d", e.out_col, result.out_col); errors++;
        end
        if (result.out_value !== e.out_value) begin
          $error("out_value expected %0h actual %0h", e.out_value, result.out_value);
          errors++;
        end
        if (result.last_of_row !== e.last_of_row) begin
          $error("last_of_row expected %0b actual %0b", e.last_of_row, result.last_of_row);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || strobe || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic pause_random();
    int g;
    if ($urandom_range(0, 3) == 0) return;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (g) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    req <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(it);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS_M: m_reg = val[4:0];
      CFG_COLS_N: n_reg = val[4:0];
      CFG_DEPTH_K: k_reg = val[4:0];
      CFG_TRANS_A: ta_reg = val[0];
      CFG_TRANS_B: tb_reg = val[0];
      CFG_ALPHA: alpha_reg = val[15:0];
      CFG_BETA: beta_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    while (row_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // corner of 6 x 6 in every store, plus the whole first row of b and c
  task automatic fill_all();
    in_item_t it;
    for (int t = 0; t < 3; t++)
      for (int a = 0; a < 256; a++) begin
        if (!((a[7:4] < 6 && a[3:0] < 6) || (a[7:4] == 0 && t != 0))) continue;
        it.req_type = t[1:0];
        it.row_index = a[7:4];
        it.col_index = a[3:0];
        it.load_value = $urandom();
        if (t < 2 && $urandom_range(0, 1)) it.load_value = $signed(it.load_value) >>> 19;
        send_item(it);
      end
  endtask

  task automatic random_phase(input int count);
    in_item_t it;
    int r;
    for (int i = 0; i < count; i++) begin
      it.req_type = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) it.req_type = REQ_COMPUTE;
      it.row_index = $urandom_range(0, 15);
      it.col_index = $urandom_range(0, 15);
      it.load_value = $urandom();
      r = $urandom_range(0, 5);
      if (r == 0) it.load_value = 32'h7FFF_FFFF;
      else if (r == 1) it.load_value = 32'h8000_0000;
      else if (r == 2) it.load_value = $signed(it.load_value) >>> 20;
      if (it.req_type == REQ_COMPUTE && !row_ready(it.row_index)) it.req_type = REQ_LOAD_C;
      pause_random();
      send_item(it);
    end
  endtask

  dir_row_t directed [$];

  initial begin
    dir_row_t d;
    in_item_t it;
    m_reg = 16; n_reg = 16; k_reg = 16; ta_reg = 0; tb_reg = 0;
    alpha_reg = 16'sd256; beta_reg = 16'sd256;
    for (int a = 0; a < 256; a++) begin a_set[a] = 0; b_set[a] = 0; c_set[a] = 0; end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 1x1 directed checks
    write_reg(CFG_ROWS_M, 1);
    write_reg(CFG_COLS_N, 1);
    write_reg(CFG_DEPTH_K, 1);
    directed = '{
      '{REQ_LOAD_A, 0, 0, 32'h0000_0100, 0, 0},
      '{REQ_LOAD_B, 0, 0, 32'h0000_0200, 0, 0},
      '{REQ_LOAD_C, 0, 0, 32'h0001_0000, 0, 0},
      '{REQ_COMPUTE, 0, 0, 0, 1, 32'h0003_0000},
      '{REQ_COMPUTE, 5, 0, 0, 0, 0},
      '{REQ_LOAD_A, 0, 0, 32'hFFFF_8000, 0, 0},
      '{REQ_LOAD_B, 0, 0, 32'h1234_8000, 0, 0},
      '{REQ_LOAD_C, 0, 0, 32'h7FFF_FFFF, 0, 0},
      '{REQ_COMPUTE, 0, 0, 0, 1, 32'h7FFF_FFFF},
      '{REQ_LOAD_B, 0, 0, 32'h0000_7FFF, 0, 0},
      '{REQ_LOAD_C, 0, 0, 32'h8000_0000, 0, 0},
      '{REQ_COMPUTE, 0, 0, 0, 1, 32'h8000_0000},
      '{REQ_LOAD_A, 15, 15, 32'hFFFF_FFFF, 0, 0},
      '{REQ_LOAD_B, 15, 15, 32'h8000_0001, 0, 0},
      '{REQ_LOAD_C, 15, 15, 32'hFFFF_FFFF, 0, 0},
      '{REQ_COMPUTE, 15, 9, 32'hFFFF_FFFF, 0, 0}
    };
    foreach (directed[i]) begin
      d = directed[i];
      it.req_type = d.kind;
      it.row_index = d.r;
      it.col_index = d.c;
      it.load_value = d.v;
      send_item(it);
      if (d.typed && (row_expected.size() != 1 || row_expected[0].out_value !== d.want)) begin
        $error("out_value expected %0h actual %0h", d.want,
               row_expected.size() ? row_expected[0].out_value : 32'hx);
        errors++;
      end
    end
    settle();

    // filled corner, then random phases over several settings
    write_reg(CFG_ROWS_M, 16);
    write_reg(CFG_COLS_N, 16);
    write_reg(CFG_DEPTH_K, 16);
    fill_all();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_ROWS_M, 0); write_reg(CFG_COLS_N, 31); write_reg(CFG_DEPTH_K, 1);
          write_reg(CFG_ALPHA, 32'h0000_7FFF); write_reg(CFG_BETA, 32'h0000_8000);
        end
        1: begin
          write_reg(CFG_TRANS_A, 1); write_reg(CFG_ROWS_M, 6);
          write_reg(CFG_COLS_N, 1); write_reg(CFG_DEPTH_K, 6);
        end
        2: begin
          write_reg(CFG_TRANS_B, 1); write_reg(CFG_ALPHA, 32'hFFFF_8000);
          write_reg(CFG_BETA, 32'h0000_0000);
        end
        default: begin
          write_reg(CFG_ROWS_M, $urandom_range(0, 31));
          write_reg(CFG_COLS_N, $urandom_range(1, 6));
          write_reg(CFG_DEPTH_K, $urandom_range(0, 6));
          write_reg(CFG_TRANS_A, $urandom_range(0, 1));
          write_reg(CFG_TRANS_B, $urandom_range(0, 1));
          write_reg(CFG_ALPHA, $urandom());
          write_reg(CFG_BETA, $urandom());
        end
      endcase
      random_phase(38);
    end
    settle();
    if (errors == 0 && row_expected.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
